@@ rtl/mtep_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

    // Result and internal field widths
    localparam int unsigned KindW  = 3;
    localparam int unsigned TickW  = 31;
    localparam int unsigned LenW   = 28;
    localparam int unsigned TempoW = 24;

    // Event kind codes
    typedef enum logic [KindW-1:0] {
        EV_NOTE_ON  = 3'd0,
        EV_NOTE_OFF = 3'd1,
        EV_TEMPO    = 3'd2,
        EV_TIME_SIG = 3'd3,
        EV_END      = 3'd4,
        EV_BAD      = 3'd5
    } t_event_kind;

    // Parser phases, one-hot
    typedef enum logic [8:0] {
        PH_DELTA  = 9'b000000001,
        PH_STATUS = 9'b000000010,
        PH_MTYPE  = 9'b000000100,
        PH_MLEN   = 9'b000001000,
        PH_MDATA  = 9'b000010000,
        PH_XLEN   = 9'b000100000,
        PH_XSKIP  = 9'b001000000,
        PH_DATA1  = 9'b010000000,
        PH_DATA2  = 9'b100000000
    } t_phase;

    // Status and meta type codes
    localparam logic [7:0] StatusMeta = 8'hFF;
    localparam logic [7:0] MetaTempo  = 8'h51;
    localparam logic [7:0] MetaTsig   = 8'h58;
    localparam logic [7:0] MetaEnd    = 8'h2F;
    localparam logic [3:0] NibSystem  = 4'hF;
    localparam logic [3:0] NibNoteOff = 4'h8;
    localparam logic [3:0] NibNoteOn  = 4'h9;
    localparam logic [3:0] NibProg    = 4'hC;
    localparam logic [3:0] NibChanPr  = 4'hD;

    localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

endpackage

`default_nettype wire

@@ rtl/midi_track_event_parser_top.sv @@
// MIDI track event parser: one track byte per transaction.
// A result is registered on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the input stalls only while a held result
// is stalled by the receiver.
// Reset (i_rst_n, synchronous, active low) clears parser state and output valid.
`timescale 1ns / 1ps
`default_nettype none

module midi_track_event_parser_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input byte channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [7:0]                   i_data_byte,
    input  wire logic                         i_track_start,
    // event channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [mtep_pkg::KindW-1:0]        o_event_kind,
    output logic [mtep_pkg::TickW-1:0]        o_event_tick,
    output logic [3:0]                        o_channel,
    output logic [6:0]                        o_note_key,
    output logic [6:0]                        o_note_velocity,
    output logic [mtep_pkg::TempoW-1:0]       o_tempo_usec,
    output logic [7:0]                        o_sig_numerator,
    output logic [7:0]                        o_sig_denom_log2
);

    // Parser state
    mtep_pkg::t_phase               r_phase, n_phase, c_phase;
    logic [mtep_pkg::LenW-1:0]      r_delta, n_delta, c_delta;
    logic [mtep_pkg::TickW-1:0]     r_tick, n_tick, c_tick;
    logic [7:0]                     r_rs, n_rs, c_rs;
    logic [7:0]                     r_meta, n_meta, c_meta;
    logic [mtep_pkg::LenW-1:0]      r_left, n_left, c_left;
    logic [6:0]                     r_first, n_first, c_first;
    logic [mtep_pkg::TempoW-1:0]    r_payload, n_payload, c_payload;
    logic [2:0]                     r_pidx, n_pidx, c_pidx;

    // Output register
    logic                           r_out_valid;
    mtep_pkg::t_event_kind          r_kind, n_kind;
    logic [mtep_pkg::TickW-1:0]     r_event_tick;
    logic [3:0]                     r_chan, n_chan;
    logic [6:0]                     r_key, n_key;
    logic [6:0]                     r_vel, n_vel;
    logic [mtep_pkg::TempoW-1:0]    r_tempo, n_tempo;
    logic [7:0]                     r_num, n_num;
    logic [7:0]                     r_den, n_den;
    logic                           n_fire;
    logic                           meta_done;

    logic                           accept;
    logic                           more;
    logic [mtep_pkg::LenW-1:0]      delta_sh;
    logic [mtep_pkg::LenW-1:0]      len_sh;
    logic [mtep_pkg::LenW-1:0]      add_val;
    logic [mtep_pkg::TickW:0]       tick_sum;
    logic [mtep_pkg::TickW-1:0]     tick_sat;

    // Handshake: take a byte unless a result is held and stalled
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign more       = i_data_byte[7];

    // Track start clears state before the byte is parsed
    always_comb begin
        if (i_track_start) begin
            c_phase   = mtep_pkg::PH_DELTA;
            c_delta   = '0;
            c_tick    = '0;
            c_rs      = '0;
            c_meta    = '0;
            c_left    = '0;
            c_first   = '0;
            c_payload = '0;
            c_pidx    = '0;
        end else begin
            c_phase   = r_phase;
            c_delta   = r_delta;
            c_tick    = r_tick;
            c_rs      = r_rs;
            c_meta    = r_meta;
            c_left    = r_left;
            c_first   = r_first;
            c_payload = r_payload;
            c_pidx    = r_pidx;
        end
    end

    // Variable-length shifts and saturating tick add
    assign delta_sh = {c_delta[mtep_pkg::LenW-8:0], i_data_byte[6:0]};
    assign len_sh   = {c_left[mtep_pkg::LenW-8:0], i_data_byte[6:0]};
    assign add_val  = (c_phase == mtep_pkg::PH_STATUS)
                    ? {{(mtep_pkg::LenW-8){1'b0}}, i_data_byte} : delta_sh;
    assign tick_sum = {1'b0, c_tick}
                    + {{(mtep_pkg::TickW+1-mtep_pkg::LenW){1'b0}}, add_val};
    assign tick_sat = tick_sum[mtep_pkg::TickW] ? mtep_pkg::TickMax
                    : tick_sum[mtep_pkg::TickW-1:0];

    // Byte parser
    always_comb begin
        n_phase   = c_phase;
        n_delta   = c_delta;
        n_tick    = c_tick;
        n_rs      = c_rs;
        n_meta    = c_meta;
        n_left    = c_left;
        n_first   = c_first;
        n_payload = c_payload;
        n_pidx    = c_pidx;
        n_fire    = 1'b0;
        n_kind    = mtep_pkg::EV_NOTE_ON;
        n_chan    = '0;
        n_key     = '0;
        n_vel     = '0;
        n_tempo   = '0;
        n_num     = '0;
        n_den     = '0;
        meta_done = 1'b0;

        case (c_phase)
            mtep_pkg::PH_STATUS: begin
                if (more) begin
                    n_rs = i_data_byte;
                    if (i_data_byte == mtep_pkg::StatusMeta) begin
                        n_phase = mtep_pkg::PH_MTYPE;
                    end else if (i_data_byte[7:4] == mtep_pkg::NibSystem) begin
                        n_left  = '0;
                        n_phase = mtep_pkg::PH_XLEN;
                    end else begin
                        n_phase = mtep_pkg::PH_DATA1;
                    end
                end else if (c_rs == 8'd0) begin
                    // no earlier status: flag it, take byte as a delta
                    n_fire = 1'b1;
                    n_kind = mtep_pkg::EV_BAD;
                    n_tick = tick_sat;
                end else if (c_rs == mtep_pkg::StatusMeta) begin
                    n_meta  = i_data_byte;
                    n_left  = '0;
                    n_phase = mtep_pkg::PH_MLEN;
                end else if (c_rs[7:4] == mtep_pkg::NibSystem) begin
                    n_left  = {{(mtep_pkg::LenW-8){1'b0}}, i_data_byte};
                    n_phase = (i_data_byte == 8'd0) ? mtep_pkg::PH_DELTA
                                                    : mtep_pkg::PH_XSKIP;
                end else begin
                    n_first = i_data_byte[6:0];
                    n_phase = (c_rs[7:4] == mtep_pkg::NibProg ||
                               c_rs[7:4] == mtep_pkg::NibChanPr)
                            ? mtep_pkg::PH_DELTA : mtep_pkg::PH_DATA2;
                end
            end
            mtep_pkg::PH_MTYPE: begin
                n_meta  = i_data_byte;
                n_left  = '0;
                n_phase = mtep_pkg::PH_MLEN;
            end
            mtep_pkg::PH_MLEN: begin
                n_left = len_sh;
                if (!more) begin
                    n_payload = '0;
                    n_pidx    = '0;
                    if (len_sh == '0) begin
                        meta_done = 1'b1;
                    end else begin
                        n_phase = mtep_pkg::PH_MDATA;
                    end
                end
            end
            mtep_pkg::PH_MDATA: begin
                // first three payload bytes fill the word from the top
                case (c_pidx)
                    3'd0: begin
                        n_payload[23:16] = c_payload[23:16] | i_data_byte;
                        n_pidx = 3'd1;
                    end
                    3'd1: begin
                        n_payload[15:8] = c_payload[15:8] | i_data_byte;
                        n_pidx = 3'd2;
                    end
                    3'd2: begin
                        n_payload[7:0] = c_payload[7:0] | i_data_byte;
                        n_pidx = 3'd3;
                    end
                    default: begin
                        n_pidx = c_pidx;
                    end
                endcase
                n_left = c_left - {{(mtep_pkg::LenW-1){1'b0}}, 1'b1};
                if (c_left == {{(mtep_pkg::LenW-1){1'b0}}, 1'b1}) begin
                    meta_done = 1'b1;
                end
            end
            mtep_pkg::PH_XLEN: begin
                n_left = len_sh;
                if (!more) begin
                    n_phase = (len_sh == '0) ? mtep_pkg::PH_DELTA
                                             : mtep_pkg::PH_XSKIP;
                end
            end
            mtep_pkg::PH_XSKIP: begin
                n_left = c_left - {{(mtep_pkg::LenW-1){1'b0}}, 1'b1};
                if (c_left == {{(mtep_pkg::LenW-1){1'b0}}, 1'b1}) begin
                    n_phase = mtep_pkg::PH_DELTA;
                end
            end
            mtep_pkg::PH_DATA1: begin
                n_first = i_data_byte[6:0];
                n_phase = (c_rs[7:4] == mtep_pkg::NibProg ||
                           c_rs[7:4] == mtep_pkg::NibChanPr)
                        ? mtep_pkg::PH_DELTA : mtep_pkg::PH_DATA2;
            end
            mtep_pkg::PH_DATA2: begin
                n_phase = mtep_pkg::PH_DELTA;
                if (c_rs[7:4] == mtep_pkg::NibNoteOn) begin
                    n_fire = 1'b1;
                    n_kind = mtep_pkg::EV_NOTE_ON;
                    n_chan = c_rs[3:0];
                    n_key  = c_first;
                    n_vel  = i_data_byte[6:0];
                end else if (c_rs[7:4] == mtep_pkg::NibNoteOff) begin
                    n_fire = 1'b1;
                    n_kind = mtep_pkg::EV_NOTE_OFF;
                    n_chan = c_rs[3:0];
                    n_key  = c_first;
                end
            end
            default: begin
                // delta time, also any stray phase code
                if (more) begin
                    n_delta = delta_sh;
                    n_phase = mtep_pkg::PH_DELTA;
                end else begin
                    n_tick  = tick_sat;
                    n_delta = '0;
                    n_phase = mtep_pkg::PH_STATUS;
                end
            end
        endcase

        // Meta event complete
        if (meta_done) begin
            n_phase = mtep_pkg::PH_DELTA;
            if (c_meta == mtep_pkg::MetaTempo) begin
                n_fire  = 1'b1;
                n_kind  = mtep_pkg::EV_TEMPO;
                n_tempo = n_payload;
            end else if (c_meta == mtep_pkg::MetaTsig) begin
                n_fire = 1'b1;
                n_kind = mtep_pkg::EV_TIME_SIG;
                n_num  = n_payload[23:16];
                n_den  = n_payload[15:8];
            end else if (c_meta == mtep_pkg::MetaEnd) begin
                n_fire = 1'b1;
                n_kind = mtep_pkg::EV_END;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mtep_pkg::PH_DELTA;
            r_delta   <= '0;
            r_tick    <= '0;
            r_rs      <= '0;
            r_meta    <= '0;
            r_left    <= '0;
            r_first   <= '0;
            r_payload <= '0;
            r_pidx    <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_delta   <= n_delta;
            r_tick    <= n_tick;
            r_rs      <= n_rs;
            r_meta    <= n_meta;
            r_left    <= n_left;
            r_first   <= n_first;
            r_payload <= n_payload;
            r_pidx    <= n_pidx;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_fire;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload, event tick is the tick before this byte's add
    always_ff @(posedge i_clk) begin
        if (accept && n_fire) begin
            r_kind       <= n_kind;
            r_event_tick <= c_tick;
            r_chan       <= n_chan;
            r_key        <= n_key;
            r_vel        <= n_vel;
            r_tempo      <= n_tempo;
            r_num        <= n_num;
            r_den        <= n_den;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_kind     = r_kind;
    assign o_event_tick     = r_event_tick;
    assign o_channel        = r_chan;
    assign o_note_key       = r_key;
    assign o_note_velocity  = r_vel;
    assign o_tempo_usec     = r_tempo;
    assign o_sig_numerator  = r_num;
    assign o_sig_denom_log2 = r_den;

endmodule

`default_nettype wire
